// File: rtl/tps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_pkg: shared types and constants of the task pending scoreboard
// Field widths, request and error codes, the controller state and the
// command that the controller broadcasts along both rows of cells.
// ----------------------------------------------------------------------------
package tps_pkg;

   localparam int ID_W    = 16;
   localparam int MASK_W  = 32;
   localparam int KIND_W  = 3;
   localparam int ERR_W   = 2;
   localparam int REQ_W   = 48;   // task_id + test_mask
   localparam int RSP_W   = 40;   // 38 result bits padded to whole bytes

   typedef enum logic [KIND_W-1:0] {
      REQ_SET      = 3'd0,
      REQ_DONE     = 3'd1,
      REQ_CLEAR    = 3'd2,
      REQ_PIPE_IN  = 3'd3,
      REQ_PIPE_OUT = 3'd4,
      REQ_QUERY    = 3'd5
   } req_kind_type;

   typedef enum logic [ERR_W-1:0] {
      ERR_OK        = 2'd0,
      ERR_ACT_FULL  = 2'd1,
      ERR_HIST_FULL = 2'd2
   } err_code_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } ctrl_state_type;

   // Broadcast to every cell of both rows
   typedef struct packed {
      logic              capture;   // latch id match against id
      logic              wr_set;    // store a successful set
      logic              wr_done;   // clear completed bits
      logic [ID_W-1:0]   id;
      logic [MASK_W-1:0] mask;
   } cell_cmd_type;

endpackage

// File: rtl/task_pending_scoreboard.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// task_pending_scoreboard: scoreboard of tasks with pending test bits
// Ordered active table and history list, each a row of cells, plus a busy
// flag, driven by set / complete / clear / pipe in / pipe out / query items.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request item: req_tuser holds the request kind,
//   req_tdata the task id and test mask. rsp_* returns exactly one result
//   item per request, in order, built from the state after the request.
//   An accepted item first matches its id in every cell (the match is
//   latched in the cell) and then updates the rows in the execute state;
//   the block takes a new item only after that update. Once the output
//   register is free, the result is built from the updated state and
//   loaded into it, and it drives rsp_tvalid. Match, first-hit and
//   close-up chains ripple through the cells.
//   While a result waits in the output register the next item is still
//   taken; a further one waits until the receiver drains the register.
//   Reset empties both tables and lowers the busy flag; no clearing pass
//   is needed, so requests are taken in the first cycle after reset.
// ----------------------------------------------------------------------------
module task_pending_scoreboard
   import tps_pkg::*;
#(
   parameter int ACTIVE_DEPTH  = 16,
   parameter int HISTORY_DEPTH = 16
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_W-1:0]  req_tdata,   // task_id[15:0], test_mask[47:16]
   input  logic [KIND_W-1:0] req_tuser,   // req_type[2:0]
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata    // in_progress[0], finished[1],
                                          // history_mask[33:2], no_task[34],
                                          // idle[35], error_code[37:36], zero
);

   localparam int ACT_CW  = $clog2(ACTIVE_DEPTH + 1);
   localparam int HIST_CW = $clog2(HISTORY_DEPTH + 1);

   ctrl_state_type    state_ff, state_in;
   logic              pend_ff, pend_in;
   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   err_code_type      err_ff, err_in;
   logic [ACT_CW-1:0]  act_count_ff, act_count_in;
   logic [HIST_CW-1:0] hist_count_ff, hist_count_in;
   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic         accept, load_rsp, rsp_free, is_exec;
   cell_cmd_type cmd;
   err_code_type err_now;

   logic [ACTIVE_DEPTH-1:0] act_occ, act_tail;
   logic [ACTIVE_DEPTH:0]   act_found, act_shift, act_res;
   logic [ID_W-1:0]         act_id_v   [ACTIVE_DEPTH];
   logic [MASK_W-1:0]       act_mask_v [ACTIVE_DEPTH];
   logic [ID_W-1:0]         act_nb_id  [ACTIVE_DEPTH];
   logic [MASK_W-1:0]       act_nb_mask[ACTIVE_DEPTH];
   logic                    act_remove, act_any;

   logic [HISTORY_DEPTH-1:0] hist_occ, hist_tail, hist_hit;
   logic [MASK_W-1:0]        hist_res[HISTORY_DEPTH+1];
   logic                     hist_any;
   logic [MASK_W-1:0]        res_hmask;

   // Active row
   assign act_found[0] = 1'b0;
   assign act_shift[0] = 1'b0;
   assign act_res[0]   = 1'b0;

   for (genvar i = 0; i < ACTIVE_DEPTH; i++) begin : g_act
      assign act_occ[i]  = (ACT_CW'(i) < act_count_ff);
      assign act_tail[i] = (ACT_CW'(i) == act_count_ff);
      if (i < ACTIVE_DEPTH - 1) begin : g_nb
         assign act_nb_id[i]   = act_id_v[i+1];
         assign act_nb_mask[i] = act_mask_v[i+1];
      end else begin : g_end
         assign act_nb_id[i]   = '0;
         assign act_nb_mask[i] = '0;
      end
      tps_act_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .occ       (act_occ[i]),
         .tail      (act_tail[i]),
         .found_in  (act_found[i]),
         .found_out (act_found[i+1]),
         .shift_in  (act_shift[i]),
         .shift_out (act_shift[i+1]),
         .nb_id     (act_nb_id[i]),
         .nb_mask   (act_nb_mask[i]),
         .id_out    (act_id_v[i]),
         .mask_out  (act_mask_v[i]),
         .res_id    (id_ff),
         .res_in    (act_res[i]),
         .res_out   (act_res[i+1])
      );
   end

   assign act_remove = act_shift[ACTIVE_DEPTH];
   assign act_any    = act_found[ACTIVE_DEPTH];

   // History row
   assign hist_res[0] = '0;

   for (genvar j = 0; j < HISTORY_DEPTH; j++) begin : g_hist
      assign hist_occ[j]  = (HIST_CW'(j) < hist_count_ff);
      assign hist_tail[j] = (HIST_CW'(j) == hist_count_ff);
      tps_hist_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .occ          (hist_occ[j]),
         .tail         (hist_tail[j]),
         .any_hit      (hist_any),
         .hit          (hist_hit[j]),
         .res_id       (id_ff),
         .res_mask_in  (hist_res[j]),
         .res_mask_out (hist_res[j+1])
      );
   end

   assign hist_any  = |hist_hit;
   assign res_hmask = hist_res[HISTORY_DEPTH];

   // Set outcome against the table fill
   always_comb begin
      err_now = ERR_OK;
      if (act_count_ff == ACT_CW'(ACTIVE_DEPTH)) begin
         err_now = ERR_ACT_FULL;
      end else if (!hist_any && (hist_count_ff == HIST_CW'(HISTORY_DEPTH))) begin
         err_now = ERR_HIST_FULL;
      end
   end

   // Controller: next state, command and bookkeeping
   always_comb begin
      is_exec  = (state_ff == ST_EXEC);
      rsp_free = ~rsp_valid_ff | rsp_tready;
      load_rsp = (state_ff == ST_IDLE) & pend_ff & rsp_free;
      req_tready = (state_ff == ST_IDLE) & (~pend_ff | rsp_free);
      accept   = req_tvalid & req_tready;

      state_in      = state_ff;
      pend_in       = pend_ff;
      kind_in       = kind_ff;
      id_in         = id_ff;
      mask_in       = mask_ff;
      err_in        = err_ff;
      act_count_in  = act_count_ff;
      hist_count_in = hist_count_ff;
      busy_in       = busy_ff;

      cmd.capture = accept;
      cmd.wr_set  = 1'b0;
      cmd.wr_done = 1'b0;
      cmd.id      = is_exec ? id_ff : req_tdata[ID_W-1:0];
      cmd.mask    = mask_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (load_rsp) begin
               pend_in = 1'b0;
            end
            if (accept) begin
               kind_in  = req_tuser;
               id_in    = req_tdata[ID_W-1:0];
               mask_in  = req_tdata[REQ_W-1:ID_W];
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            err_in   = ERR_OK;
            pend_in  = 1'b1;
            state_in = ST_IDLE;
            unique case (req_kind_type'(kind_ff))
               REQ_SET: begin
                  err_in = err_now;
                  if (err_now == ERR_OK) begin
                     cmd.wr_set   = 1'b1;
                     act_count_in = act_count_ff + ACT_CW'(1);
                     if (!hist_any) begin
                        hist_count_in = hist_count_ff + HIST_CW'(1);
                     end
                  end
               end
               REQ_DONE: begin
                  cmd.wr_done = 1'b1;
                  if (act_remove) begin
                     act_count_in = act_count_ff - ACT_CW'(1);
                  end
               end
               REQ_CLEAR: begin
                  act_count_in  = '0;
                  hist_count_in = '0;
                  busy_in       = 1'b0;
               end
               REQ_PIPE_IN:  busy_in = 1'b1;
               REQ_PIPE_OUT: busy_in = 1'b0;
               default: begin
               end
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Build the result from the state after the update
   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (load_rsp) begin
         rsp_data_in = {2'b00, err_ff, ~busy_ff & (act_count_ff == '0),
                        (act_count_ff == '0), res_hmask, (res_hmask == '0),
                        act_res[ACTIVE_DEPTH]};
      end
      rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp_tready);
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Hold payload
   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      id_ff       <= id_in;
      mask_ff     <= mask_in;
      err_ff      <= err_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_ff       <= 1'b0;
         act_count_ff  <= '0;
         hist_count_ff <= '0;
         busy_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         act_count_ff  <= act_count_in;
         hist_count_ff <= hist_count_in;
         busy_ff       <= busy_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Checks
   a_act_bound: assert property (@(posedge clock) disable iff (reset)
      act_count_ff <= ACT_CW'(ACTIVE_DEPTH))
      else $error("active count beyond depth");

   a_hist_bound: assert property (@(posedge clock) disable iff (reset)
      hist_count_ff <= HIST_CW'(HISTORY_DEPTH))
      else $error("history count beyond depth");

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted item not executed");

   a_remove_hit: assert property (@(posedge clock) disable iff (reset)
      (is_exec && act_remove) |-> act_any)
      else $error("close-up without an active hit");

   a_hist_unique: assert property (@(posedge clock) disable iff (reset)
      is_exec |-> $onehot0(hist_hit))
      else $error("history id held twice");

endmodule

// File: rtl/tps_act_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_act_cell: one entry of the ordered active table
// Holds an id and a pending mask. A first-hit chain finds the oldest match,
// and a shift chain closes the row up when that entry's mask runs out.
// ----------------------------------------------------------------------------
module tps_act_cell
   import tps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cell_cmd_type      cmd,
   input  logic              occ,
   input  logic              tail,
   input  logic              found_in,
   output logic              found_out,
   input  logic              shift_in,
   output logic              shift_out,
   input  logic [ID_W-1:0]   nb_id,
   input  logic [MASK_W-1:0] nb_mask,
   output logic [ID_W-1:0]   id_out,
   output logic [MASK_W-1:0] mask_out,
   input  logic [ID_W-1:0]   res_id,
   input  logic              res_in,
   output logic              res_out
);

   logic [ID_W-1:0]   id_ff, id_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              hit_ff, hit_in;
   logic              first;
   logic [MASK_W-1:0] cleared;
   logic              take_nb;

   // Locate the oldest hit and decide whether to close up
   always_comb begin
      first     = cmd.wr_done & hit_ff & ~found_in;
      cleared   = mask_ff & ~cmd.mask;
      take_nb   = shift_in | (first & (cleared == '0));
      shift_out = take_nb;
      found_out = found_in | hit_ff;
      res_out   = res_in | (occ & (id_ff == res_id));
      id_out    = id_ff;
      mask_out  = mask_ff;
   end

   // Next entry contents
   always_comb begin
      hit_in  = cmd.capture ? (occ & (id_ff == cmd.id)) : hit_ff;
      id_in   = id_ff;
      mask_in = mask_ff;
      priority if (take_nb) begin
         id_in   = nb_id;
         mask_in = nb_mask;
      end else if (first) begin
         mask_in = cleared;
      end else if (cmd.wr_set && tail) begin
         id_in   = cmd.id;
         mask_in = cmd.mask;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      mask_ff <= mask_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

endmodule

// File: rtl/tps_hist_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tps_hist_cell: one entry of the history list
// Holds the single id/mask pair of a task; a set replaces it, a complete
// clears bits in it, and a free tail cell takes a new id.
// ----------------------------------------------------------------------------
module tps_hist_cell
   import tps_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cell_cmd_type      cmd,
   input  logic              occ,
   input  logic              tail,
   input  logic              any_hit,
   output logic              hit,
   input  logic [ID_W-1:0]   res_id,
   input  logic [MASK_W-1:0] res_mask_in,
   output logic [MASK_W-1:0] res_mask_out
);

   logic [ID_W-1:0]   id_ff, id_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              hit_ff, hit_in;

   // Pass the matching mask on down the row
   always_comb begin
      hit          = hit_ff;
      res_mask_out = res_mask_in | ((occ && (id_ff == res_id)) ? mask_ff : '0);
   end

   // Replace, append or clear bits
   always_comb begin
      hit_in  = cmd.capture ? (occ & (id_ff == cmd.id)) : hit_ff;
      id_in   = id_ff;
      mask_in = mask_ff;
      priority if (cmd.wr_set && hit_ff) begin
         mask_in = cmd.mask;
      end else if (cmd.wr_set && tail && !any_hit) begin
         id_in   = cmd.id;
         mask_in = cmd.mask;
      end else if (cmd.wr_done && hit_ff) begin
         mask_in = mask_ff & ~cmd.mask;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      mask_ff <= mask_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

endmodule
